// ===== rtl/stq_pkg.sv =====
// Shared types and constants for the sorted timer queue.
package stq_pkg;

	localparam int TIME_W      = 48;
	localparam int ID_W        = 32;
	localparam int DUR_W       = 27;
	localparam int MAXT_W      = 5;
	localparam int MAX_RESULTS = 16;
	localparam int RES_CNT_W   = 5;

	localparam logic [DUR_W-1:0]  REM_MAX       = {DUR_W{1'b1}};
	localparam logic [MAXT_W-1:0] MAXT_RESET    = 5'd16;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;
	localparam logic [1:0] CMD_LIST   = 2'd3;

	localparam logic [2:0] KIND_ADDED    = 3'd0;
	localparam logic [2:0] KIND_FULL     = 3'd1;
	localparam logic [2:0] KIND_REMOVED  = 3'd2;
	localparam logic [2:0] KIND_NOTFOUND = 3'd3;
	localparam logic [2:0] KIND_EXPIRED  = 3'd4;
	localparam logic [2:0] KIND_LISTED   = 3'd5;
	localparam logic [2:0] KIND_EMPTY    = 3'd6;

	typedef struct packed {
		logic [TIME_W-1:0] expiry;
		logic [ID_W-1:0]   ident;
	} entry_t;

	// What a cell shows its neighbors.
	typedef struct packed {
		logic   valid;
		logic   le;
		entry_t ent;
	} cell_link_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_ROTATE,
		OP_POP
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_REMOVE,
		ST_TICK,
		ST_LIST
	} state_t;

endpackage

// ===== rtl/sorted_timer_queue_core.sv =====
// Sorted timer queue: sequencer, output register and the chain of timer cells.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, cmd, duration_seconds,     | request in
//          | target_id                                      |
//  out     | out_valid, out_stall, kind, timer_id,          | results out
//          | remaining_seconds, last                        |
//  cfg     | cfg_wr_en, cfg_wr_data (max_timers)            | write only
//
// Add gives one result. Remove makes one ring rotation of the cell chain per cycle,
// one per entry, then answers; list rotates the chain round once, one result per
// entry, or an empty answer; tick pops the expired entries, one chain shift per
// result. Output stalls hold the sequencer, but not the remove rotations.
// Reset clears the cell valid bits at once; entry data is not cleared.
// A new request is taken once the previous one is done and its last result, if any, is registered.
module sorted_timer_queue_core #(
	parameter int CAPACITY = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 cmd,
	input  logic [stq_pkg::DUR_W-1:0]  duration_seconds,
	input  logic [stq_pkg::ID_W-1:0]   target_id,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [2:0]                 kind,
	output logic [stq_pkg::ID_W-1:0]   timer_id,
	output logic [stq_pkg::DUR_W-1:0]  remaining_seconds,
	output logic                       last,
	input  logic                       cfg_wr_en,
	input  logic [stq_pkg::MAXT_W-1:0] cfg_wr_data
);
	import stq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > MAXT_W) ? CW : MAXT_W;

	state_t              state_q, state_d;
	logic [MAXT_W-1:0]   max_timers_q;
	logic [TIME_W-1:0]   now_q;
	logic [ID_W-1:0]     next_id_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       step_q;
	logic                found_q;
	logic [RES_CNT_W-1:0] n_q;
	logic [ID_W-1:0]     target_q;
	logic [TIME_W-1:0]   exp_q;

	logic                out_valid_q;
	logic [2:0]          kind_q;
	logic [ID_W-1:0]     timer_id_q;
	logic [DUR_W-1:0]    rem_q;
	logic                last_q;

	cell_link_t links  [CAPACITY];
	cell_link_t lefts  [CAPACITY];
	cell_link_t rights [CAPACITY];
	logic [CAPACITY-1:0] vld;

	cell_op_t         op;
	entry_t           new_ent;
	logic             in_acc, out_free, full, hit, head_due, next_due;
	logic [ID_W-1:0]  new_id;
	logic [TIME_W-1:0] diff;
	logic [DUR_W-1:0] head_rem;

	logic             emit, e_last, cnt_inc, cnt_dec, step_dec, found_set, n_inc, id_adv;
	logic [2:0]       e_kind;
	logic [ID_W-1:0]  e_id;
	logic [DUR_W-1:0] e_rem;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign new_id  = next_id_q + 32'd1;
	assign new_ent = '{expiry: exp_q, ident: new_id};

	assign full = (LW'(cnt_q) >= LW'(max_timers_q)) || (cnt_q == CW'(CAPACITY));
	assign hit  = links[0].valid && (links[0].ent.ident == target_q);
	assign head_due = links[0].valid && (links[0].ent.expiry <= now_q);
	assign next_due = links[1].valid && (links[1].ent.expiry <= now_q);

	assign diff = links[0].ent.expiry - now_q;
	always_comb begin
		if (links[0].ent.expiry <= now_q) begin
			head_rem = '0;
		end else if (|diff[TIME_W-1:DUR_W]) begin
			head_rem = REM_MAX;
		end else begin
			head_rem = diff[DUR_W-1:0];
		end
	end

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign vld[i] = links[i].valid;
		if (i == 0) begin : g_first
			assign lefts[i] = '{valid: 1'b1, le: 1'b1, ent: '0};
		end else begin : g_mid_l
			assign lefts[i] = links[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rights[i] = '{valid: 1'b0, le: 1'b0, ent: '0};
		end else begin : g_mid_r
			assign rights[i] = links[i+1];
		end
		stq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.new_ent   (new_ent),
			.head      (links[0].ent),
			.left      (lefts[i]),
			.right     (rights[i]),
			.self_link (links[i])
		);
	end

	// sequencer outputs
	always_comb begin
		op        = OP_HOLD;
		emit      = 1'b0;
		e_kind    = KIND_ADDED;
		e_id      = '0;
		e_rem     = '0;
		e_last    = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		step_dec  = 1'b0;
		found_set = 1'b0;
		n_inc     = 1'b0;
		id_adv    = 1'b0;
		case (state_q)
			ST_ADD: begin
				if (out_free) begin
					emit   = 1'b1;
					e_last = 1'b1;
					if (full) begin
						e_kind = KIND_FULL;
					end else begin
						op      = OP_INSERT;
						cnt_inc = 1'b1;
						id_adv  = 1'b1;
						e_kind  = KIND_ADDED;
						e_id    = new_id;
					end
				end
			end
			ST_REMOVE: begin
				if (step_q != '0) begin
					step_dec = 1'b1;
					// drop only the first match, keep rotating the rest
					if (!found_q && hit) begin
						op        = OP_POP;
						cnt_dec   = 1'b1;
						found_set = 1'b1;
					end else begin
						op = OP_ROTATE;
					end
				end else if (out_free) begin
					emit   = 1'b1;
					e_last = 1'b1;
					e_id   = target_q;
					e_kind = found_q ? KIND_REMOVED : KIND_NOTFOUND;
				end
			end
			ST_TICK: begin
				if (head_due && out_free) begin
					op      = OP_POP;
					cnt_dec = 1'b1;
					emit    = 1'b1;
					e_kind  = KIND_EXPIRED;
					e_id    = links[0].ent.ident;
					e_last  = (n_q == RES_CNT_W'(MAX_RESULTS - 1)) || !next_due;
					n_inc   = 1'b1;
				end
			end
			ST_LIST: begin
				if (step_q == '0) begin
					if (out_free) begin
						emit   = 1'b1;
						e_last = 1'b1;
						e_kind = KIND_EMPTY;
					end
				end else if (n_q == RES_CNT_W'(MAX_RESULTS)) begin
					op       = OP_ROTATE;
					step_dec = 1'b1;
				end else if (out_free) begin
					op       = OP_ROTATE;
					step_dec = 1'b1;
					emit     = 1'b1;
					e_kind   = KIND_LISTED;
					e_id     = links[0].ent.ident;
					e_rem    = head_rem;
					e_last   = (step_q == CW'(1)) || (n_q == RES_CNT_W'(MAX_RESULTS - 1));
					n_inc    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (cmd)
						CMD_ADD:    state_d = ST_ADD;
						CMD_REMOVE: state_d = ST_REMOVE;
						CMD_TICK:   state_d = ST_TICK;
						default:    state_d = ST_LIST;
					endcase
				end
			end
			ST_ADD: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_REMOVE: begin
				if (step_q == '0 && out_free) state_d = ST_IDLE;
			end
			ST_TICK: begin
				if (!head_due || (emit && e_last)) state_d = ST_IDLE;
			end
			ST_LIST: begin
				if (step_q == '0) begin
					if (out_free) state_d = ST_IDLE;
				end else if (step_dec && step_q == CW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			max_timers_q <= MAXT_RESET;
			now_q        <= '0;
			next_id_q    <= '0;
			cnt_q        <= '0;
			step_q       <= '0;
			found_q      <= 1'b0;
			n_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) max_timers_q <= cfg_wr_data;
			if (in_acc) begin
				step_q  <= cnt_q;
				found_q <= 1'b0;
				n_q     <= '0;
				if (cmd == CMD_TICK) now_q <= now_q + 48'd1;
			end else begin
				if (step_dec)  step_q  <= step_q - CW'(1);
				if (found_set) found_q <= 1'b1;
				if (n_inc)     n_q     <= n_q + RES_CNT_W'(1);
			end
			if (id_adv)  next_id_q <= new_id;
			if (cnt_inc) cnt_q <= cnt_q + CW'(1);
			if (cnt_dec) cnt_q <= cnt_q - CW'(1);
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			target_q <= target_id;
			exp_q    <= now_q + TIME_W'(duration_seconds);
		end
		if (emit) begin
			kind_q     <= e_kind;
			timer_id_q <= e_id;
			rem_q      <= e_rem;
			last_q     <= e_last;
		end
	end

	assign out_valid         = out_valid_q;
	assign kind              = kind_q;
	assign timer_id          = timer_id_q;
	assign remaining_seconds = rem_q;
	assign last              = last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_cnt_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld) == int'(cnt_q))
		else $error("entry count disagrees with valid cells");

	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && links[0].valid && links[1].valid)
			|-> (links[0].ent.expiry <= links[1].ent.expiry))
		else $error("front entries out of order");

	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result written over a stalled result");

	a_idle_no_cell_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (op == OP_HOLD && !emit))
		else $error("chain moved while idle");

endmodule

// ===== rtl/stq_cell.sv =====
// One slot of the sorted timer chain: holds an entry and trades it with its neighbors.
module stq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  stq_pkg::cell_op_t   op,
	input  stq_pkg::entry_t     new_ent,
	input  stq_pkg::entry_t     head,
	input  stq_pkg::cell_link_t left,
	input  stq_pkg::cell_link_t right,
	output stq_pkg::cell_link_t self_link
);
	import stq_pkg::*;

	logic   valid_q;
	entry_t ent_q;
	logic   valid_d;
	entry_t ent_d;
	logic   le;

	assign le        = valid_q && (ent_q.expiry <= new_ent.expiry);
	assign self_link = '{valid: valid_q, le: le, ent: ent_q};

	always_comb begin
		valid_d = valid_q;
		ent_d   = ent_q;
		case (op)
			OP_INSERT: begin
				if (!le) begin
					if (left.le) begin
						valid_d = 1'b1;
						ent_d   = new_ent;
					end else begin
						valid_d = left.valid;
						ent_d   = left.ent;
					end
				end
			end
			OP_ROTATE: begin
				// last valid cell takes the front entry
				if (right.valid) begin
					valid_d = 1'b1;
					ent_d   = right.ent;
				end else if (valid_q) begin
					ent_d = head;
				end
			end
			OP_POP: begin
				valid_d = right.valid;
				ent_d   = right.ent;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

endmodule

// ===== tb/sorted_timer_queue_core_tb.sv =====
// Self-checking testbench for the sorted timer queue core.
module sorted_timer_queue_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int CLK_PERIOD  = 4;
	localparam int SETTLE_CYC  = 40;
	localparam int LONG_HOLD   = 300;
	localparam int PHASE_CMDS  = 25;
	localparam logic [DUR_W-1:0] DUR_TOP = 27'd86676039;

	typedef struct {
		logic [1:0]       op;
		logic [DUR_W-1:0] dur;
		logic [ID_W-1:0]  tid;
	} timer_cmd_t;

	typedef struct {
		logic [2:0]       kind;
		logic [ID_W-1:0]  id;
		logic [DUR_W-1:0] rem;
		logic             last;
	} timer_answer_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          cmd = CMD_LIST;
	logic [DUR_W-1:0]    duration_seconds = '0;
	logic [ID_W-1:0]     target_id = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [2:0]          kind;
	logic [ID_W-1:0]     timer_id;
	logic [DUR_W-1:0]    remaining_seconds;
	logic                last;
	logic                cfg_wr_en = 1'b0;
	logic [MAXT_W-1:0]   cfg_wr_data = '0;

	// Shadow of the timer store
	logic [TIME_W-1:0]   now_s;
	logic [TIME_W-1:0]   due_a [QUEUE_DEPTH];
	logic [ID_W-1:0]     id_a [QUEUE_DEPTH];
	int                  live_cnt;
	logic [ID_W-1:0]     id_ctr;
	logic [MAXT_W-1:0]   limit_reg;

	timer_cmd_t          cmd_backlog [$];
	timer_answer_t       answers_due [$];
	int                  cmds_queued = 0;
	int                  cmds_taken = 0;
	int                  results_seen = 0;
	int                  mismatches = 0;
	int                  kind_seen [7];
	logic [ID_W-1:0]     ids_handed_out = '0;

	int                  gap_max = 3;
	int                  stall_mode = 1;
	logic                long_hold_req = 1'b0;
	logic                long_hold_done = 1'b0;
	int                  hold_left = 0;
	int                  stall_tick = 0;
	int                  burst_left = 0;
	int                  gap_left = 0;

	logic [MAXT_W-1:0]   phase_limit [0:8] = '{5'd3, 5'd31, 5'd1, 5'd16, 5'd7, 5'd0,
		5'd12, 5'd16, 5'd2};

	sorted_timer_queue_core #(
		.CAPACITY(QUEUE_DEPTH)
	) u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.cmd               (cmd),
		.duration_seconds  (duration_seconds),
		.target_id         (target_id),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.kind              (kind),
		.timer_id          (timer_id),
		.remaining_seconds (remaining_seconds),
		.last              (last),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 50) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
	endtask

	function automatic void drop_entry(input int pos);
		int i;
		for (i = pos; i + 1 < live_cnt; i++) begin
			due_a[i] = due_a[i + 1];
			id_a[i] = id_a[i + 1];
		end
		live_cnt--;
	endfunction

	// Update the shadow store for one accepted request and queue its answers.
	task automatic apply_timer_cmd(input logic [1:0] op, input logic [DUR_W-1:0] dur,
			input logic [ID_W-1:0] tid);
		timer_answer_t     batch [MAX_RESULTS];
		int                n;
		int                i;
		int                pos;
		int                lim;
		logic [TIME_W-1:0] due_at;
		logic [TIME_W-1:0] left;
		n = 0;
		case (op)
			CMD_ADD: begin
				lim = (limit_reg < QUEUE_DEPTH) ? int'(limit_reg) : QUEUE_DEPTH;
				if (live_cnt >= lim) begin
					batch[0] = '{KIND_FULL, 32'd0, 27'd0, 1'b0};
				end else begin
					id_ctr = id_ctr + 1'b1;
					due_at = now_s + TIME_W'(dur);
					pos = 0;
					// Equal expiry goes behind the ones already queued
					while (pos < live_cnt && due_a[pos] <= due_at) pos++;
					for (i = live_cnt; i > pos; i--) begin
						due_a[i] = due_a[i - 1];
						id_a[i] = id_a[i - 1];
					end
					due_a[pos] = due_at;
					id_a[pos] = id_ctr;
					live_cnt++;
					batch[0] = '{KIND_ADDED, id_ctr, 27'd0, 1'b0};
				end
				n = 1;
			end
			CMD_REMOVE: begin
				pos = -1;
				for (i = 0; i < live_cnt; i++) begin
					if (pos < 0 && id_a[i] == tid) pos = i;
				end
				if (pos >= 0) begin
					drop_entry(pos);
					batch[0] = '{KIND_REMOVED, tid, 27'd0, 1'b0};
				end else begin
					batch[0] = '{KIND_NOTFOUND, tid, 27'd0, 1'b0};
				end
				n = 1;
			end
			CMD_TICK: begin
				now_s = now_s + 1'b1;
				while (n < MAX_RESULTS && live_cnt > 0 && due_a[0] <= now_s) begin
					batch[n] = '{KIND_EXPIRED, id_a[0], 27'd0, 1'b0};
					drop_entry(0);
					n++;
				end
			end
			default: begin
				if (live_cnt == 0) begin
					batch[0] = '{KIND_EMPTY, 32'd0, 27'd0, 1'b0};
					n = 1;
				end
				for (i = 0; i < live_cnt && n < MAX_RESULTS; i++) begin
					left = (due_a[i] > now_s) ? due_a[i] - now_s : '0;
					if (left > TIME_W'(REM_MAX)) left = TIME_W'(REM_MAX);
					batch[n] = '{KIND_LISTED, id_a[i], left[DUR_W-1:0], 1'b0};
					n++;
				end
			end
		endcase
		for (i = 0; i < n; i++) begin
			batch[i].last = (i == n - 1);
			answers_due.push_back(batch[i]);
		end
	endtask

	task automatic queue_cmd(input logic [1:0] op, input logic [DUR_W-1:0] dur,
			input logic [ID_W-1:0] tid);
		timer_cmd_t c;
		c.op = op;
		c.dur = dur;
		c.tid = tid;
		if (op == CMD_ADD) ids_handed_out++;
		cmd_backlog.push_back(c);
		cmds_queued++;
	endtask

	// Adds are the most frequent request, mostly with short durations so ticks keep
	// expiring entries; removes aim at recently issued ids, with some fully random ids mixed in.
	task automatic queue_random_cmds(input int count);
		int               pick;
		int               r;
		logic [1:0]       op;
		logic [DUR_W-1:0] dur;
		logic [ID_W-1:0]  tid;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) op = CMD_ADD;
			else if (pick < 60) op = CMD_REMOVE;
			else if (pick < 85) op = CMD_TICK;
			else op = CMD_LIST;
			r = $urandom_range(0, 9);
			if (r < 7) dur = DUR_W'($urandom_range(0, 8));
			else if (r < 9) dur = DUR_W'($urandom_range(0, 300));
			else dur = DUR_W'($urandom_range(0, int'(DUR_TOP)));
			if ($urandom_range(0, 9) < 7) tid = ids_handed_out - $urandom_range(0, 24);
			else tid = $urandom;
			queue_cmd(op, dur, tid);
		end
	endtask

	// Wait until every request is taken and answered, then let the block go quiet.
	task automatic settle();
		while (cmds_taken != cmds_queued || answers_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_limit(input logic [MAXT_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		limit_reg = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Request driver: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		timer_cmd_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_timer_cmd(cmd, duration_seconds, target_id);
				cmds_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					nxt = cmd_backlog[0];
					cmd_backlog.delete(0);
					in_valid <= 1'b1;
					cmd <= nxt.op;
					duration_seconds <= nxt.dur;
					target_id <= nxt.tid;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 10);
						gap_left = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result stall pattern, with one long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (long_hold_req && !long_hold_done) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 2) == 0);
				default: begin
					stall_tick = (stall_tick + 1) % 7;
					out_stall <= (stall_tick < 3);
				end
			endcase
		end
	end

	// Result monitor
	always @(posedge clk) begin
		timer_answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (kind < 7) kind_seen[kind]++;
			if (answers_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result kind %0d id %0d", kind, timer_id));
			end else begin
				want = answers_due[0];
				answers_due.delete(0);
				if (kind !== want.kind)
					flag_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
				if (timer_id !== want.id)
					flag_mismatch($sformatf("timer_id %0d, want %0d", timer_id, want.id));
				if (remaining_seconds !== want.rem)
					flag_mismatch($sformatf("remaining_seconds %0d, want %0d",
						remaining_seconds, want.rem));
				if (last !== want.last)
					flag_mismatch($sformatf("last %0b, want %0b", last, want.last));
			end
		end
	end

	initial begin
		int ph;
		now_s = '0;
		live_cnt = 0;
		id_ctr = '0;
		limit_reg = MAXT_RESET;
		for (ph = 0; ph < 7; ph++) kind_seen[ph] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Empty queue, unknown ids, zero and a long duration, equal expiry
		queue_cmd(CMD_LIST, '0, '0);
		queue_cmd(CMD_TICK, '0, '0);
		queue_cmd(CMD_REMOVE, '0, 32'd0);
		queue_cmd(CMD_REMOVE, '0, 32'hFFFF_FFFF);
		queue_cmd(CMD_ADD, 27'd0, '0);
		queue_cmd(CMD_ADD, DUR_TOP, '0);
		queue_cmd(CMD_ADD, 27'd5, '0);
		queue_cmd(CMD_ADD, 27'd5, '0);
		queue_cmd(CMD_ADD, 27'd2, '0);
		queue_cmd(CMD_LIST, '0, '0);
		queue_cmd(CMD_REMOVE, '0, 32'd3);
		queue_cmd(CMD_REMOVE, '0, 32'd3);
		queue_cmd(CMD_TICK, '0, '0);
		queue_cmd(CMD_TICK, '0, '0);
		queue_cmd(CMD_TICK, '0, '0);
		queue_cmd(CMD_LIST, '0, '0);
		settle();

		// Tight limits: one timer, then none at all
		write_limit(5'd1);
		queue_cmd(CMD_ADD, 27'd10, '0);
		queue_cmd(CMD_ADD, 27'd10, '0);
		queue_cmd(CMD_LIST, '0, '0);
		settle();
		write_limit(5'd0);
		queue_cmd(CMD_ADD, 27'd1, '0);
		queue_cmd(CMD_LIST, '0, '0);
		settle();

		// Fill to capacity behind a long result hold-off, then list and expire
		write_limit(5'd16);
		stall_mode = 0;
		gap_max = 0;
		long_hold_req = 1'b1;
		repeat (18) queue_cmd(CMD_ADD, DUR_W'($urandom_range(0, 3)), '0);
		queue_cmd(CMD_LIST, '0, '0);
		repeat (4) queue_cmd(CMD_TICK, '0, '0);
		settle();

		for (ph = 0; ph < 9; ph++) begin
			write_limit(phase_limit[ph]);
			stall_mode = ph % 3;
			gap_max = (ph % 4 == 1) ? 0 : 6;
			queue_random_cmds(PHASE_CMDS);
			settle();
		end

		$display("Checked %0d results from %0d requests, limits 0 to 31",
			results_seen, cmds_taken);
		$display("Added %0d full %0d removed %0d missing %0d expired %0d listed %0d empty %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
			kind_seen[5], kind_seen[6]);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d requests taken of %0d", cmds_taken, cmds_queued);
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sorted_timer_queue_core.f =====
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/sorted_timer_queue_core.sv
tb/sorted_timer_queue_core_tb.sv
